### sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bounded integer stack: operation codes,
// controller states and the command and status groups between controller
// and datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int ModeW  = 3;
  localparam int DataW  = 32;
  localparam int CountW = 9;

  localparam logic [ModeW-1:0] MODE_PUSH   = 3'd0;
  localparam logic [ModeW-1:0] MODE_POP    = 3'd1;
  localparam logic [ModeW-1:0] MODE_PEEK   = 3'd2;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [ModeW-1:0] MODE_SEARCH = 3'd4;

  localparam logic [CountW-1:0] CAP_RESET = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } bis_state_t;

  typedef struct packed {
    logic take;
    logic set_err;
    logic push;
    logic pop;
    logic clear;
    logic rd_top;
    logic scan_start;
    logic scan_step;
    logic data_load;
    logic found_load;
    logic out_load;
  } bis_cmd_t;

  typedef struct packed {
    logic [ModeW-1:0] op;
    logic             empty;
    logic             full;
    logic             match;
    logic             scan_last;
    logic             out_free;
  } bis_stat_t;

endpackage

### sv/bis_ctrl.sv
// ----------------------------------------------------------------------------
// bis_ctrl
// Controller of the bounded integer stack: takes one item at a time, steps
// the datapath through the operation and hands the result to the output.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bis_pkg::bis_stat_t  stat,
  output bis_pkg::bis_cmd_t   cmd
);

  import bis_pkg::*;

  bis_state_t state;
  bis_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        case (stat.op)
          MODE_PUSH: begin
            if (stat.full) begin
              cmd.set_err = 1'b1;
            end else begin
              cmd.push = 1'b1;
            end
          end
          MODE_POP: begin
            if (stat.empty) begin
              cmd.set_err = 1'b1;
            end else begin
              cmd.rd_top = 1'b1;
              cmd.pop    = 1'b1;
              state_next = ST_READ;
            end
          end
          MODE_PEEK: begin
            if (stat.empty) begin
              cmd.set_err = 1'b1;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = ST_READ;
            end
          end
          MODE_CLEAR: begin
            cmd.clear = 1'b1;
          end
          MODE_SEARCH: begin
            if (!stat.empty) begin
              cmd.rd_top     = 1'b1;
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_READ: begin
        cmd.data_load = 1'b1;
        state_next    = ST_DONE;
      end
      ST_SCAN: begin
        if (stat.match) begin
          cmd.found_load = 1'b1;
          state_next     = ST_DONE;
        end else if (stat.scan_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/bis_dp.sv
// ----------------------------------------------------------------------------
// bis_dp
// Datapath of the bounded integer stack: entry memory with registered read,
// top pointer, capacity register, scan index, result and output registers.
// ----------------------------------------------------------------------------
module bis_dp #(
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bis_pkg::bis_cmd_t                cmd,
  output bis_pkg::bis_stat_t               stat,
  input  logic [bis_pkg::ModeW-1:0]        mode,
  input  logic signed [bis_pkg::DataW-1:0] value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bis_pkg::CountW-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             status,
  output logic signed [bis_pkg::DataW-1:0] data_out,
  output logic signed [bis_pkg::CountW-1:0] found_index,
  output logic [bis_pkg::CountW-1:0]       item_count,
  output logic                             is_empty,
  output logic                             is_full
);

  import bis_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1);
  localparam int XW = (PW > CountW) ? PW : CountW;

  logic [DataW-1:0]  mem [DEPTH];
  logic [DataW-1:0]  rd_data;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  logic [ModeW-1:0]  op;
  logic [DataW-1:0]  key;
  logic [PW-1:0]     ptr;
  logic [PW-1:0]     ptr_m1;
  logic [CountW-1:0] cap;
  logic [XW-1:0]     cap_x;
  logic [XW-1:0]     cap_eff;
  logic [XW-1:0]     ptr_x;
  logic [XW-1:0]     idx_x;
  logic [AW-1:0]     scan_idx;
  logic              full;

  logic              res_status;
  logic [DataW-1:0]  res_data;
  logic [CountW-1:0] res_found;

  assign cfg_ready = 1'b1;

  assign ptr_m1  = ptr - 1'b1;
  assign ptr_x   = XW'(ptr);
  assign idx_x   = XW'(scan_idx);
  assign cap_x   = XW'(cap);
  assign cap_eff = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
  assign full    = (ptr_x >= cap_eff);

  assign rd_en   = cmd.rd_top | cmd.scan_step;
  assign rd_addr = cmd.scan_step ? (scan_idx - 1'b1) : ptr_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[ptr[AW-1:0]] <= key;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.push) begin
      ptr <= ptr + 1'b1;
    end else if (cmd.pop) begin
      ptr <= ptr_m1;
    end else if (cmd.clear) begin
      ptr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op  <= mode;
      key <= value;
    end
    if (cmd.scan_start) begin
      scan_idx <= ptr_m1[AW-1:0];
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_status <= 1'b0;
      res_data   <= '0;
      res_found  <= '1;
    end else begin
      if (cmd.set_err) begin
        res_status <= 1'b1;
      end
      if (cmd.data_load) begin
        res_data <= rd_data;
      end
      if (cmd.found_load) begin
        res_found <= idx_x[CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      data_out    <= res_data;
      found_index <= res_found;
      item_count  <= ptr_x[CountW-1:0];
      is_empty    <= (ptr == '0);
      is_full     <= full;
    end
  end

  assign stat.op        = op;
  assign stat.empty     = (ptr == '0);
  assign stat.full      = full;
  assign stat.match     = (rd_data == key);
  assign stat.scan_last = (scan_idx == '0);
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

### sv/bounded_integer_stack_top.sv
// ----------------------------------------------------------------------------
// bounded_integer_stack_top
// Bounded LIFO stack of signed 32-bit words with push, pop, peek, clear
// and top-down search.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries mode and value; one item is
// worked on at a time; in_stall is high until its result is loaded for output.
// Output channel (out_valid/out_stall) carries one result per item through
// an output register, so the next item is taken while a result waits.
// Configuration channel (cfg_valid/cfg_ready) writes capacity_limit; it is
// always ready. The user must write it only while no item is in flight; the
// block itself does not enforce this.
// Steps per item: push, clear and unused modes act on the taken item and
// form the result; pop and peek add one registered memory read; search
// compares entries from the top down, one per cycle through the memory
// read port, and compares at most DEPTH entries.
// Reset empties the stack, sets capacity_limit to 256 and drops any result.
// While out_stall is high the result holds and a finished item waits in the
// controller until the output register frees.
// ----------------------------------------------------------------------------
module bounded_integer_stack_top #(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bis_pkg::ModeW-1:0]         mode,
  input  logic signed [bis_pkg::DataW-1:0]  value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bis_pkg::CountW-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              status,
  output logic signed [bis_pkg::DataW-1:0]  data_out,
  output logic signed [bis_pkg::CountW-1:0] found_index,
  output logic [bis_pkg::CountW-1:0]        item_count,
  output logic                              is_empty,
  output logic                              is_full
);

  import bis_pkg::*;

  bis_cmd_t  cmd;
  bis_stat_t stat;

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .value       (value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .data_out    (data_out),
    .found_index (found_index),
    .item_count  (item_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

endmodule

### sv/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks of the bounded integer stack, bound to the top level.
// ----------------------------------------------------------------------------
module bis_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [bis_pkg::ModeW-1:0]         mode,
  input logic signed [bis_pkg::DataW-1:0]  value,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [bis_pkg::CountW-1:0]        cfg_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              status,
  input logic signed [bis_pkg::DataW-1:0]  data_out,
  input logic signed [bis_pkg::CountW-1:0] found_index,
  input logic [bis_pkg::CountW-1:0]        item_count,
  input logic                              is_empty,
  input logic                              is_full
);

  import bis_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) &&
      $stable(item_count) && $stable(found_index) && $stable(status))
    else $error("stalled result changed");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (item_count == '0)))
    else $error("empty flag disagrees with count");

  a_err_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (data_out == '0) && (found_index == '1))
    else $error("error result carries data");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (found_index != '1) |->
      !status && (data_out == '0) && (found_index < item_count))
    else $error("search hit inconsistent");

endmodule

bind bounded_integer_stack_top bis_checker u_bis_checker (.*);
